### sv/ilist_pkg.sv
package ilist_pkg;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] cell_cmd_type;

   localparam func_type OP_READ   = 2'd0;
   localparam func_type OP_INSERT = 2'd1;
   localparam func_type OP_DELETE = 2'd2;
   localparam func_type OP_SEARCH = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_RANGE    = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   // hold, shift up from left neighbor, shift down from right neighbor, rotate prefix
   localparam cell_cmd_type CMD_HOLD = 2'd0;
   localparam cell_cmd_type CMD_INS  = 2'd1;
   localparam cell_cmd_type CMD_DEL  = 2'd2;
   localparam cell_cmd_type CMD_ROT  = 2'd3;

   localparam int DATA_W = 32;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

### sv/ilist_cell.sv
module ilist_cell #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  ilist_pkg::cell_ctl_type             ctl,
   input  logic [IDX_W-1:0]                    pos,
   input  logic [IDX_W-1:0]                    last,
   input  logic signed [ilist_pkg::DATA_W-1:0] left_data,
   input  logic signed [ilist_pkg::DATA_W-1:0] right_data,
   input  logic signed [ilist_pkg::DATA_W-1:0] head_data,
   output logic signed [ilist_pkg::DATA_W-1:0] data
);
   import ilist_pkg::*;

   localparam logic [IDX_W-1:0] IDX = INDEX[IDX_W-1:0];

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.cmd)
         CMD_INS: begin
            if (IDX > pos) begin
               data_in = left_data;
            end else if (IDX == pos) begin
               data_in = ctl.value;
            end
         end
         CMD_DEL: begin
            if (IDX >= pos) begin
               data_in = right_data;
            end
         end
         CMD_ROT: begin
            if (IDX < last) begin
               data_in = right_data;
            end else if (IDX == last) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### sv/indexed_list_insert_delete_search.sv
// Insert and delete: result valid the cycle after accept; the next item is accepted
// once the result slot is free. Read and search: the list rotates once through the cell
// chain past the compare at cell 0, one entry per cycle (the last only when the result
// slot is free), and ends in its order. Empty-list and out-of-range cases skip the scan.
// Synchronous active-high reset empties the list and drops any pending result.
module indexed_list_insert_delete_search #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position[7:0], value[39:8]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // found_index[6:0], read_data[38:7], fill_count[46:39]
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   import ilist_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PW    = (CNT_W > 8) ? CNT_W : 8;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                     state_ff,  state_in;
   logic [CNT_W-1:0]         count_ff,  count_in;
   logic [PW-1:0]            step_ff,   step_in;
   logic [PW-1:0]            pos_ff,    pos_in;
   func_type                 op_ff,     op_in;
   logic signed [DATA_W-1:0] val_ff,    val_in;
   logic                     hit_ff,    hit_in;
   logic [6:0]               hidx_ff,   hidx_in;
   logic signed [DATA_W-1:0] rdat_ff,   rdat_in;

   logic                     rsp_valid_ff,  rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [6:0]               rsp_fidx_ff,   rsp_fidx_in;
   logic signed [DATA_W-1:0] rsp_rdata_ff,  rsp_rdata_in;
   logic [7:0]               rsp_fill_ff,   rsp_fill_in;

   logic signed [DATA_W-1:0] cell_data [DEPTH];
   cell_ctl_type             ctl;
   logic [PW-1:0]            pos_ext;
   logic [PW-1:0]            cnt_ext;
   logic [PW-1:0]            last_ext;
   logic                     out_free;
   logic                     accept;
   func_type                 func;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] head;
   logic                     match;
   logic                     hit_fin;

   assign func      = req_tuser;
   assign req_value = req_tdata[39:8];
   assign pos_ext   = PW'(req_tdata[7:0]);
   assign cnt_ext   = PW'(count_ff);
   assign last_ext  = cnt_ext - PW'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_tvalid && req_tready;
   assign head      = cell_data[0];
   assign match     = (op_ff == OP_SEARCH) && !hit_ff && (head == val_ff);
   assign hit_fin   = hit_ff || match;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      hit_in        = hit_ff;
      hidx_in       = hidx_ff;
      rdat_in       = rdat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_fill_in   = rsp_fill_ff;
      ctl.cmd       = CMD_HOLD;
      ctl.value     = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = ST_OK;
               rsp_fidx_in   = '0;
               rsp_rdata_in  = '0;
               rsp_fill_in   = 8'(count_ff);
               op_in         = func;
               pos_in        = pos_ext;
               val_in        = req_value;
               step_in       = '0;
               hit_in        = 1'b0;
               hidx_in       = '0;
               rdat_in       = '0;
               unique case (func)
                  OP_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        ctl.cmd     = CMD_INS;
                        count_in    = count_ff + CNT_W'(1);
                        rsp_fill_in = 8'(count_in);
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        ctl.cmd     = CMD_DEL;
                        count_in    = count_ff - CNT_W'(1);
                        rsp_fill_in = 8'(count_in);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         default: begin
            if ((step_ff != last_ext) || out_free) begin
               ctl.cmd = CMD_ROT;
               step_in = step_ff + PW'(1);
               if (match) begin
                  hit_in  = 1'b1;
                  hidx_in = 7'(step_ff);
               end
               if ((op_ff == OP_READ) && (step_ff == pos_ff)) begin
                  rdat_in = head;
               end
               if (step_ff == last_ext) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_fill_in  = 8'(count_ff);
                  if (op_ff == OP_READ) begin
                     rsp_status_in = ST_OK;
                     rsp_fidx_in   = '0;
                     rsp_rdata_in  = rdat_in;
                  end else begin
                     rsp_status_in = hit_fin ? ST_OK : ST_NOTFOUND;
                     rsp_fidx_in   = hit_fin ? hidx_in : 7'd0;
                     rsp_rdata_in  = '0;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      hit_ff        <= hit_in;
      hidx_ff       <= hidx_in;
      rdat_ff       <= rdat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      ilist_cell #(
         .IDX_W (PW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (pos_ext),
         .last       (last_ext),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (head),
         .data       (cell_data[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_fill_ff, rsp_rdata_ff, rsp_fidx_ff};

endmodule

### sv/ilist_checker.sv
module ilist_checker #(
   parameter int DEPTH = 128
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import ilist_pkg::*;

   localparam int FILL_MAX = (DEPTH > 255) ? 255 : DEPTH;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 255) || (rsp_tdata[46:39] <= 8'(FILL_MAX)))
      else $error("fill count above depth");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> (rsp_tdata[46:39] == 8'(DEPTH)))
      else $error("full status with list not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == ST_NOTFOUND) || (rsp_tuser == ST_RANGE)
         || (rsp_tuser == ST_FULL)) |-> (rsp_tdata[38:0] == '0))
      else $error("error result carries data");

endmodule

bind indexed_list_insert_delete_search ilist_checker #(
   .DEPTH (DEPTH)
) u_ilist_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### verif/testbench.sv
module testbench;
   import ilist_pkg::*;

   localparam int LIST_DEPTH   = 128;
   localparam int RANDOM_ITEMS = 1350;
   localparam int SETTLE       = 200;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef struct {
      status_type               status;
      logic [6:0]               found_index;
      logic signed [DATA_W-1:0] read_data;
      logic [7:0]               fill_count;
   } answer_type;

   typedef enum {PH_GROW, PH_MIX_UP, PH_SHRINK, PH_MIX_DOWN} phase_type;

   // tracks the list contents and the answers still owed by the block
   class list_mirror_type;
      logic signed [DATA_W-1:0] cells [LIST_DEPTH];
      int                       fill;
      int                       errors;
      answer_type               pending_answers[$];

      function new();
         fill = 0;
         errors = 0;
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      function void note_op(func_type op, logic [7:0] pos, logic signed [DATA_W-1:0] val);
         answer_type ans;
         bit         hit;
         ans.status      = ST_OK;
         ans.found_index = '0;
         ans.read_data   = '0;
         hit             = 1'b0;
         case (op)
            OP_READ: begin
               if (pos < fill) ans.read_data = cells[pos];
               else ans.status = ST_RANGE;
            end
            OP_INSERT: begin
               if (fill >= LIST_DEPTH) ans.status = ST_FULL;
               else if (pos > fill) ans.status = ST_RANGE;
               else begin
                  for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = val;
                  fill++;
               end
            end
            OP_DELETE: begin
               if (pos >= fill) ans.status = ST_RANGE;
               else begin
                  for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            default: begin
               for (int i = 0; i < fill && !hit; i++) begin
                  if (cells[i] == val) begin
                     hit = 1'b1;
                     ans.found_index = i[6:0];
                  end
               end
               if (!hit) ans.status = ST_NOTFOUND;
            end
         endcase
         ans.fill_count = fill[7:0];
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(status_type st, logic [6:0] fidx,
                                 logic signed [DATA_W-1:0] rdata, logic [7:0] fcnt);
         answer_type ans;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected item: status %0d found_index %0d read_data %h fill %0d",
                     $time, st, fidx, rdata, fcnt);
            errors++;
            return;
         end
         ans = pending_answers.pop_front();
         if (st !== ans.status) begin
            $display("%0t: status expected %0d actual %0d", $time, ans.status, st);
            errors++;
         end
         if (fidx !== ans.found_index) begin
            $display("%0t: found_index expected %0d actual %0d", $time, ans.found_index, fidx);
            errors++;
         end
         if (rdata !== ans.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, ans.read_data, rdata);
            errors++;
         end
         if (fcnt !== ans.fill_count) begin
            $display("%0t: fill_count expected %0d actual %0d", $time, ans.fill_count, fcnt);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;  // position[7:0], value[39:8]
   logic [1:0]  req_tuser  = '0;  // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // found_index[6:0], read_data[38:7], fill_count[46:39]
   logic [1:0]  rsp_tuser;        // status[1:0]

   list_mirror_type mirror;
   int              idle_max    = 14;
   int              cycle_count = 0;

   indexed_list_insert_delete_search #(.DEPTH(LIST_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("indexed_list_insert_delete_search test failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (idle_max == 0) return 0;
      return $urandom_range(0, idle_max);
   endfunction

   function automatic logic [31:0] pick_value();
      int w;
      w = $urandom_range(0, 9);
      if (w < 5) return $urandom;
      if (w < 8) return $urandom_range(0, 7);
      if (w == 8) return 32'h8000_0000 + $urandom_range(0, 3);
      return 32'h7FFF_FFFF - $urandom_range(0, 3);
   endfunction

   task automatic send_op(func_type op, logic [7:0] pos, logic [31:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {val, pos};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      mirror.note_op(op, pos, val);
   endtask

   task automatic random_op(phase_type ph);
      int          w;
      int          cnt;
      func_type    op;
      logic [7:0]  pos;
      logic [31:0] val;
      cnt = mirror.fill;
      w   = $urandom_range(0, 99);
      case (ph)
         PH_GROW:   op = (w < 70) ? OP_INSERT : (w < 75) ? OP_DELETE :
                         (w < 87) ? OP_READ : OP_SEARCH;
         PH_SHRINK: op = (w < 70) ? OP_DELETE : (w < 78) ? OP_INSERT :
                         (w < 89) ? OP_READ : OP_SEARCH;
         default:   op = (w < 25) ? OP_INSERT : (w < 50) ? OP_DELETE :
                         (w < 75) ? OP_READ : OP_SEARCH;
      endcase
      if ($urandom_range(0, 99) < 12) pos = 8'($urandom_range(0, 255));
      else if (op == OP_INSERT) pos = 8'($urandom_range(0, cnt));
      else if (cnt > 0) pos = 8'($urandom_range(0, cnt - 1));
      else pos = '0;
      if (op == OP_SEARCH && cnt > 0 && $urandom_range(0, 1) == 1)
         val = mirror.cells[$urandom_range(0, cnt - 1)];
      else
         val = pick_value();
      send_op(op, pos, val);
   endtask

   // result side: random stall per item, then check
   initial begin : answer_side
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mirror.check_answer(rsp_tuser, rsp_tdata[6:0], rsp_tdata[38:7], rsp_tdata[46:39]);
      end
   end

   initial begin : stimulus
      int        sent;
      int        tail;
      int        mix_left;
      phase_type ph;
      mirror = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list
      send_op(OP_READ,   8'd0,   32'h0000_0000);
      send_op(OP_DELETE, 8'd0,   32'h0000_0000);
      send_op(OP_SEARCH, 8'd0,   32'h0000_0000);
      send_op(OP_INSERT, 8'd1,   32'h1111_1111);
      send_op(OP_INSERT, 8'd255, 32'h2222_2222);
      // build: front, append, middle, duplicate at end
      send_op(OP_INSERT, 8'd0,   32'h8000_0000);
      send_op(OP_INSERT, 8'd1,   32'h7FFF_FFFF);
      send_op(OP_INSERT, 8'd1,   32'hFFFF_FFFF);
      send_op(OP_INSERT, 8'd0,   32'h0000_0000);
      send_op(OP_INSERT, 8'd4,   32'h8000_0000);
      for (int i = 0; i < 5; i++) send_op(OP_READ, i[7:0], 32'h0000_0000);
      send_op(OP_READ,   8'd5,   32'h0000_0000);
      send_op(OP_READ,   8'd128, 32'h0000_0000);
      send_op(OP_SEARCH, 8'd0,   32'h8000_0000);
      send_op(OP_SEARCH, 8'd0,   32'h7FFF_FFFF);
      send_op(OP_SEARCH, 8'd0,   32'h1234_5678);
      send_op(OP_DELETE, 8'd4,   32'h0000_0000);
      send_op(OP_DELETE, 8'd0,   32'h0000_0000);
      send_op(OP_DELETE, 8'd1,   32'h0000_0000);
      send_op(OP_DELETE, 8'd5,   32'h0000_0000);
      send_op(OP_DELETE, 8'd255, 32'h0000_0000);

      // grow to full, mix, drain to empty, mix, repeat
      sent     = 0;
      tail     = 8;
      mix_left = 60;
      ph       = PH_GROW;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 40 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         random_op(ph);
         sent++;
         if (ph == PH_MIX_UP || ph == PH_MIX_DOWN) begin
            mix_left--;
            if (mix_left == 0) begin
               ph = (ph == PH_MIX_UP) ? PH_SHRINK : PH_GROW;
               tail = 8;
            end
         end else if ((ph == PH_GROW && mirror.fill == LIST_DEPTH) ||
                      (ph == PH_SHRINK && mirror.fill == 0)) begin
            if (tail == 0) begin
               ph = (ph == PH_GROW) ? PH_MIX_UP : PH_MIX_DOWN;
               mix_left = 60;
            end else begin
               tail--;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mirror.errors == 0)
         $display("indexed_list_insert_delete_search test passed");
      else
         $display("indexed_list_insert_delete_search test failed");
      $finish;
   end

endmodule

### indexed_list_insert_delete_search.f
sv/ilist_pkg.sv
sv/ilist_cell.sv
sv/indexed_list_insert_delete_search.sv
sv/ilist_checker.sv
verif/testbench.sv
